@@ hdl/double_ended_queue_unit_macros.svh @@
// Assertion macros shared by the deque RTL modules.
// Used by deq_ctrl and deq_dp; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// expr must hold at every edge outside reset
`define DEQ_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("deque check failed");

// cons must hold in the same cycle as ante
`define DEQ_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// cons must hold in the cycle after ante
`define DEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

@@ hdl/deq_pkg.sv @@
// Types and constants of the double-ended queue unit.
// No dependencies; imported by every deque module but deq_ram.
package deq_pkg;

   localparam int DEPTH_DEF = 256;
   localparam int WORD_W    = 32;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT  = 2'd0,
      CMD_POP_FRONT   = 2'd1,
      CMD_INJECT_BACK = 2'd2,
      CMD_EJECT_BACK  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } stat_code_type;

   typedef struct packed {
      cmd_type                  command;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] removed_value;
      stat_code_type            status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic load_read;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic read_ok;
   } dp_stat_type;

endpackage

@@ hdl/deq_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/deq_ctrl.sv @@
// Deque controller: sequences capture, execute, read and response.
// Depends on deq_pkg and double_ended_queue_unit_macros.svh.
`include "double_ended_queue_unit_macros.svh"

module deq_ctrl import deq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.read_ok ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_RESP);
   assign ctl.capture   = (state_ff == ST_IDLE) && req_valid;
   assign ctl.exec      = (state_ff == ST_EXEC);
   assign ctl.load_read = (state_ff == ST_READ);

   `DEQ_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall, ctl.exec)
   `DEQ_ASSERT_NEXT(a_read_path, clock, reset, ctl.exec && stat.read_ok, ctl.load_read)
   `DEQ_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && req_stall)

endmodule

@@ hdl/deq_dp.sv @@
// Deque datapath: head index, occupancy, ring address math, entry RAM, result register.
// Depends on deq_pkg, deq_ram and double_ended_queue_unit_macros.svh.
`include "double_ended_queue_unit_macros.svh"

module deq_dp import deq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type ctl,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W:0]   WRAP     = (CNT_W + 1)'(DEPTH);

   cmd_type                  cmd_ff, cmd_in;
   logic signed [WORD_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         occ_ff, occ_in;
   rsp_type                  rsp_ff, rsp_in;

   logic             is_full, is_empty, is_insert, is_back;
   logic [IDX_W-1:0] head_dec, head_inc, back_slot, ram_addr;
   logic [CNT_W-1:0] offset;
   logic [CNT_W:0]   back_sum, back_wrap;
   logic             ram_we, ram_re;
   logic [WORD_W-1:0] ram_rdata;

   assign is_full   = (occ_ff == FULL_CNT);
   assign is_empty  = (occ_ff == '0);
   assign is_insert = cmd_ff inside {CMD_PUSH_FRONT, CMD_INJECT_BACK};
   assign is_back   = cmd_ff inside {CMD_INJECT_BACK, CMD_EJECT_BACK};

   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;

   // back slot: head + occ for inject, head + occ - 1 for eject; sum < 2*DEPTH unless eject finds it empty
   assign offset    = (cmd_ff == CMD_INJECT_BACK) ? occ_ff : occ_ff - 1'b1;
   assign back_sum  = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(offset);
   assign back_wrap = (back_sum >= WRAP) ? back_sum - WRAP : back_sum;
   assign back_slot = back_wrap[IDX_W-1:0];

   always_comb begin
      case (cmd_ff)
         CMD_PUSH_FRONT: ram_addr = head_dec;
         CMD_POP_FRONT:  ram_addr = head_ff;
         default:        ram_addr = back_slot;
      endcase
   end

   assign ram_we       = ctl.exec && is_insert && !is_full;
   assign ram_re       = ctl.exec && !is_insert && !is_empty;
   assign stat.read_ok = !is_insert && !is_empty;

   deq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (value_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      cmd_in   = ctl.capture ? req_data.command : cmd_ff;
      value_in = ctl.capture ? req_data.value : value_ff;
      head_in  = head_ff;
      occ_in   = occ_ff;
      rsp_in   = rsp_ff;
      if (ctl.exec) begin
         case (cmd_ff)
            CMD_PUSH_FRONT: begin
               if (!is_full) begin
                  head_in = head_dec;
                  occ_in  = occ_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (!is_empty) begin
                  head_in = head_inc;
                  occ_in  = occ_ff - 1'b1;
               end
            end
            CMD_INJECT_BACK: begin
               if (!is_full) occ_in = occ_ff + 1'b1;
            end
            default: begin
               if (!is_empty) occ_in = occ_ff - 1'b1;
            end
         endcase
         rsp_in.removed_value = '0;
         if (is_insert) begin
            rsp_in.status = is_full ? STAT_FULL : STAT_OK;
         end else begin
            rsp_in.status = is_empty ? STAT_EMPTY : STAT_OK;
         end
      end
      if (ctl.load_read) begin
         rsp_in.removed_value = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `DEQ_ASSERT_ALWAYS(a_occ_range, clock, reset, occ_ff <= FULL_CNT)
   `DEQ_ASSERT_NEXT(a_idle_hold, clock, reset, !ctl.exec, $stable(occ_ff) && $stable(head_ff))
   `DEQ_ASSERT_NEXT(a_back_head, clock, reset, ctl.exec && is_back, $stable(head_ff))

endmodule

@@ hdl/double_ended_queue_unit.sv @@
// A push, inject or refused command passes through EXEC, then RESP, after transfer;
// a successful pop or eject adds READ between them for the registered entry RAM read.
// One command in flight: a new transfer is taken the cycle after the result transfer,
// so no new command is taken until the last result has been transferred.
// Reset (synchronous, high) empties the queue and zeroes the head index at once;
// entry RAM contents are not cleared.
module double_ended_queue_unit import deq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_cmd_type ctl;
   dp_stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

@@ sim/deque_checker.sv @@
`timescale 1ns / 100ps
// Checker for double_ended_queue_unit: keeps its own ring model of the deque,
// predicts one result per command transfer and compares result transfers in order.
// Depends on deq_pkg.
module deque_checker import deq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding,
   output int      results_seen,
   output int      full_seen,
   output int      empty_seen
);

   logic signed [WORD_W-1:0] ring [DEPTH];
   int      head;
   int      level;
   int      errors;
   int      n_results;
   int      n_full;
   int      n_empty;
   rsp_type pending_results[$];

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   task automatic apply_command(input req_type cmd);
      rsp_type want;
      int      slot;
      want.removed_value = '0;
      want.status        = STAT_OK;
      case (cmd.command)
         CMD_PUSH_FRONT: begin
            if (level == DEPTH) begin
               want.status = STAT_FULL;
            end else begin
               head       = (head + DEPTH - 1) % DEPTH;
               ring[head] = cmd.value;
               level++;
            end
         end
         CMD_POP_FRONT: begin
            if (level == 0) begin
               want.status = STAT_EMPTY;
            end else begin
               want.removed_value = ring[head];
               head = (head + 1) % DEPTH;
               level--;
            end
         end
         CMD_INJECT_BACK: begin
            if (level == DEPTH) begin
               want.status = STAT_FULL;
            end else begin
               slot       = (head + level) % DEPTH;
               ring[slot] = cmd.value;
               level++;
            end
         end
         default: begin
            if (level == 0) begin
               want.status = STAT_EMPTY;
            end else begin
               slot = (head + level - 1) % DEPTH;
               want.removed_value = ring[slot];
               level--;
            end
         end
      endcase
      pending_results.push_back(want);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      n_results++;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result transfer with none expected: value %0d status %0d",
                                   got.removed_value, got.status));
         return;
      end
      want = pending_results.pop_front();
      if (want.status == STAT_FULL) n_full++;
      if (want.status == STAT_EMPTY) n_empty++;
      if (got.removed_value !== want.removed_value)
         report_mismatch($sformatf("removed_value %0d, expected %0d",
                                   got.removed_value, want.removed_value));
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head  = 0;
         level = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) apply_command(req_data);
      end
      mismatches   <= errors;
      outstanding  <= pending_results.size();
      results_seen <= n_results;
      full_seen    <= n_full;
      empty_seen   <= n_empty;
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Top-level testbench of double_ended_queue_unit: clock, reset, command stimulus
// and result-side stall; checking is done by deque_checker (deque_checker.sv, deq_pkg).
module tb import deq_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;
   int results_seen;
   int full_seen;
   int empty_seen;

   int level;
   int sent;
   int gap_pct;
   int stall_pct;
   int stall_left;
   bit idle_on;

   double_ended_queue_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   deque_checker check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .full_seen    (full_seen),
      .empty_seen   (empty_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, outstanding);
      $display("*** FAILED ***");
      $finish;
   end

   // random result-side stall bursts, only while idle_on is set
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type rand_insert();
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_INJECT_BACK;
   endfunction

   function automatic cmd_type rand_removal();
      return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_EJECT_BACK;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic issue(input cmd_type op, input logic [WORD_W-1:0] word);
      if (sent % 32 == 0) begin
         gap_pct   = $urandom_range(0, 2) * 15;
         stall_pct = $urandom_range(0, 2) * 15;
      end
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {op, word};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
      case (op)
         CMD_PUSH_FRONT, CMD_INJECT_BACK: if (level < DEPTH_DEF) level++;
         default:                         if (level > 0) level--;
      endcase
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      idle_on   = 1'b1;
      level     = 0;
      sent      = 0;
      gap_pct   = 0;
      stall_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: removals when empty, extreme words, last-word removal at each end
      issue(CMD_POP_FRONT, 32'h0);
      issue(CMD_EJECT_BACK, 32'hffff_ffff);
      issue(CMD_PUSH_FRONT, 32'h7fff_ffff);
      issue(CMD_PUSH_FRONT, 32'h8000_0000);
      issue(CMD_INJECT_BACK, 32'h0);
      issue(CMD_INJECT_BACK, 32'hffff_ffff);
      issue(CMD_PUSH_FRONT, 32'h1);
      issue(CMD_INJECT_BACK, 32'h5555_5555);
      issue(CMD_POP_FRONT, 32'h0);
      issue(CMD_EJECT_BACK, 32'h0);
      issue(CMD_POP_FRONT, 32'h0);
      issue(CMD_EJECT_BACK, 32'h0);
      issue(CMD_POP_FRONT, 32'h0);
      issue(CMD_EJECT_BACK, 32'h0);
      issue(CMD_POP_FRONT, 32'h0);
      issue(CMD_INJECT_BACK, 32'haaaa_aaaa);
      issue(CMD_POP_FRONT, 32'h0);
      issue(CMD_PUSH_FRONT, 32'h1234_5678);
      issue(CMD_EJECT_BACK, 32'h0);
      issue(CMD_EJECT_BACK, 32'h0);

      // fill to full, then refused inserts
      while (level < DEPTH_DEF) begin
         if ($urandom_range(0, 63) == 0) issue(rand_removal(), rand_word());
         else issue(rand_insert(), rand_word());
      end
      repeat (4) issue(rand_insert(), rand_word());
      issue(rand_removal(), rand_word());
      issue(rand_insert(), rand_word());
      issue(rand_insert(), rand_word());

      // drain to empty, then refused removals
      while (level > 0) begin
         if ($urandom_range(0, 63) == 0) issue(rand_insert(), rand_word());
         else issue(rand_removal(), rand_word());
      end
      repeat (3) issue(rand_removal(), rand_word());
      issue(rand_insert(), rand_word());
      issue(rand_removal(), rand_word());
      issue(rand_removal(), rand_word());

      // back-to-back mix with no idling on either side
      idle_on = 1'b0;
      repeat (25) issue(cmd_type'($urandom_range(0, 3)), rand_word());
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d commands: fill to full, drain to empty, wrap at both ends.", sent);
      $display("Checked %0d results, %0d refused as full, %0d refused as empty.",
               results_seen, full_seen, empty_seen);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
